### hdl/sle_pkg.sv
// Shared types and constants for the STA/LTA energy ratio core.
// Holds controller/datapath command and status structs and the state encoding.
// No dependencies.
`default_nettype none

package sle_pkg;

    // Configuration port
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_SHORT_WINDOW = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_WINDOW  = 1'b1;

    localparam logic [CFG_W-1:0] SHORT_WINDOW_RST = 11'd32;
    localparam logic [CFG_W-1:0] LONG_WINDOW_RST  = 11'd512;

    // Result format: unsigned Q11.16
    localparam int RATIO_W = 27;
    localparam int FRAC_W  = 16;
    localparam int INT_W   = RATIO_W - FRAC_W;
    localparam int QCNT_W  = $clog2(RATIO_W);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_RD_LONG,
        S_RD_SHORT,
        S_INC_A,
        S_INC_B,
        S_INC_C,
        S_WRITE,
        S_SWEEP,
        S_DRAIN_A,
        S_DRAIN_B,
        S_MUL_INIT,
        S_MUL,
        S_CHECK,
        S_DIV,
        S_FINISH
    } t_state;

    typedef enum logic [1:0] {
        RD_SWEEP,
        RD_OLD_LONG,
        RD_OLD_SHORT
    } t_rd_src;

    typedef enum logic {
        SQ_MEM,
        SQ_SAMPLE
    } t_sq_sel;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_CLEAR,
        ACC_ADD,
        ACC_SUB
    } t_acc_op;

    typedef struct packed {
        logic    load;
        logic    write;
        logic    rd_en;
        t_rd_src rd_src;
        t_sq_sel sq_sel;
        t_acc_op long_op;
        t_acc_op short_op;
        logic    sweep;
        logic    mul_init;
        logic    mul_step;
        logic    div_init;
        logic    div_step;
        logic    out_load;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic sweep_last;
        logic mul_last;
        logic div_last;
        logic zero;
        logic ovf;
    } t_status;

endpackage

`default_nettype wire

### hdl/sle_sample_if.sv
// Sample channel: valid/ready handshake carrying one signed sample.
// Standalone; no package dependency.
`default_nettype none

interface sle_sample_if #(
    parameter int SAMPLE_BITS = 24
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

### hdl/sle_result_if.sv
// Result channel: valid/ready handshake carrying ratio and status.
// Depends on sle_pkg for the ratio width.
`default_nettype none

interface sle_result_if ();
    logic                         valid;
    logic                         ready;
    logic [sle_pkg::RATIO_W-1:0]  ratio;
    logic                         status;

    modport source (output valid, output ratio, output status, input ready);
    modport sink   (input valid, input ratio, input status, output ready);
endinterface

`default_nettype wire

### hdl/sle_ctrl.sv
// Sequencing state machine for the STA/LTA core: issues datapath commands.
// Depends on sle_pkg (state, command and status types).
`default_nettype none

module sle_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire logic             i_out_ready,
    input  wire logic             i_cfg_we,
    input  wire sle_pkg::t_status i_status,
    output sle_pkg::t_cmd         o_cmd,
    output logic                  o_in_ready,
    output logic                  o_out_valid
);

    sle_pkg::t_state r_state, n_state;
    logic            r_sums_ok, n_sums_ok;
    logic            r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sle_pkg::S_IDLE;
            r_sums_ok   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sums_ok   <= n_sums_ok;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_sums_ok  = r_sums_ok;
        o_cmd      = '0;
        o_in_ready = 1'b0;

        unique case (r_state)
            sle_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = sle_pkg::S_DECIDE;
                end
            end
            sle_pkg::S_DECIDE: begin
                if (i_status.full && r_sums_ok) begin
                    n_state = sle_pkg::S_RD_LONG;
                end else begin
                    n_state = sle_pkg::S_WRITE;
                end
            end
            sle_pkg::S_RD_LONG: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_src = sle_pkg::RD_OLD_LONG;
                n_state      = sle_pkg::S_RD_SHORT;
            end
            sle_pkg::S_RD_SHORT: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_src = sle_pkg::RD_OLD_SHORT;
                o_cmd.sq_sel = sle_pkg::SQ_MEM;
                n_state      = sle_pkg::S_INC_A;
            end
            sle_pkg::S_INC_A: begin
                // drop the sample leaving the long window, store the new one
                o_cmd.sq_sel  = sle_pkg::SQ_MEM;
                o_cmd.long_op = sle_pkg::ACC_SUB;
                o_cmd.write   = 1'b1;
                n_state       = sle_pkg::S_INC_B;
            end
            sle_pkg::S_INC_B: begin
                o_cmd.sq_sel   = sle_pkg::SQ_SAMPLE;
                o_cmd.short_op = sle_pkg::ACC_SUB;
                n_state        = sle_pkg::S_INC_C;
            end
            sle_pkg::S_INC_C: begin
                o_cmd.long_op  = sle_pkg::ACC_ADD;
                o_cmd.short_op = sle_pkg::ACC_ADD;
                n_state        = sle_pkg::S_MUL_INIT;
            end
            sle_pkg::S_WRITE: begin
                o_cmd.write    = 1'b1;
                o_cmd.long_op  = sle_pkg::ACC_CLEAR;
                o_cmd.short_op = sle_pkg::ACC_CLEAR;
                if (i_status.full) begin
                    n_state = sle_pkg::S_SWEEP;
                end else begin
                    n_state = sle_pkg::S_IDLE;
                end
            end
            sle_pkg::S_SWEEP: begin
                o_cmd.sweep  = 1'b1;
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_src = sle_pkg::RD_SWEEP;
                o_cmd.sq_sel = sle_pkg::SQ_MEM;
                if (i_status.sweep_last) begin
                    n_state = sle_pkg::S_DRAIN_A;
                end
            end
            sle_pkg::S_DRAIN_A: begin
                o_cmd.sq_sel = sle_pkg::SQ_MEM;
                n_state      = sle_pkg::S_DRAIN_B;
            end
            sle_pkg::S_DRAIN_B: begin
                n_state = sle_pkg::S_MUL_INIT;
            end
            sle_pkg::S_MUL_INIT: begin
                o_cmd.mul_init = 1'b1;
                n_sums_ok      = 1'b1;
                n_state        = sle_pkg::S_MUL;
            end
            sle_pkg::S_MUL: begin
                o_cmd.mul_step = 1'b1;
                if (i_status.mul_last) begin
                    n_state = sle_pkg::S_CHECK;
                end
            end
            sle_pkg::S_CHECK: begin
                o_cmd.div_init = 1'b1;
                if (i_status.zero || i_status.ovf) begin
                    n_state = sle_pkg::S_FINISH;
                end else begin
                    n_state = sle_pkg::S_DIV;
                end
            end
            sle_pkg::S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = sle_pkg::S_FINISH;
                end
            end
            sle_pkg::S_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = sle_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = sle_pkg::S_IDLE;
            end
        endcase

        // window sizes changed: rebuild sums from history on the next result
        if (i_cfg_we) begin
            n_sums_ok = 1'b0;
        end
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

### hdl/sle_datapath.sv
// Datapath of the STA/LTA core: sample history RAM, squarer, energy sums,
// shift-add multiplier and restoring divider. Depends on sle_pkg.
`default_nettype none

module sle_datapath #(
    parameter int MAX_WINDOW  = 1024,
    parameter int SAMPLE_BITS = 24
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic signed [SAMPLE_BITS-1:0]   i_sample,
    input  wire logic                            i_cfg_we,
    input  wire logic [sle_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [sle_pkg::CFG_W-1:0]       i_cfg_data,
    input  wire sle_pkg::t_cmd                   i_cmd,
    output sle_pkg::t_status                     o_status,
    output logic [sle_pkg::RATIO_W-1:0]          o_ratio,
    output logic                                 o_zero_flag
);

    localparam int AW    = $clog2(MAX_WINDOW);
    localparam int LB    = $clog2(MAX_WINDOW + 1);
    localparam int XW    = LB + 1;
    localparam int MW    = (LB > sle_pkg::CFG_W) ? LB : sle_pkg::CFG_W;
    localparam int SQW   = 2 * SAMPLE_BITS - 1;
    localparam int EW    = SQW + AW;
    localparam int PW    = EW + LB;
    localparam int BCW   = $clog2(LB);
    localparam int INT_W = sle_pkg::INT_W;
    localparam int RW    = sle_pkg::RATIO_W;

    // ---------------- configuration and clamping ----------------
    logic [sle_pkg::CFG_W-1:0] r_short_window, r_long_window;
    logic [MW-1:0]             w_lw_ext, w_sw_ext;
    logic [LB-1:0]             w_lw, w_sw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_window <= sle_pkg::SHORT_WINDOW_RST;
            r_long_window  <= sle_pkg::LONG_WINDOW_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                sle_pkg::REG_SHORT_WINDOW: r_short_window <= i_cfg_data;
                sle_pkg::REG_LONG_WINDOW:  r_long_window  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        w_lw_ext = MW'(r_long_window);
        w_sw_ext = MW'(r_short_window);
        if (w_lw_ext == '0) begin
            w_lw = LB'(1);
        end else if (w_lw_ext > MW'(MAX_WINDOW)) begin
            w_lw = LB'(MAX_WINDOW);
        end else begin
            w_lw = LB'(w_lw_ext);
        end
        if (w_sw_ext == '0) begin
            w_sw = LB'(1);
        end else if (w_sw_ext > MW'(w_lw)) begin
            w_sw = w_lw;
        end else begin
            w_sw = LB'(w_sw_ext);
        end
    end

    // ---------------- sample capture and fill count ----------------
    logic signed [SAMPLE_BITS-1:0] r_sample;
    logic [LB-1:0]                 r_fill;
    logic [LB:0]                   w_fill_inc;

    assign w_fill_inc = {1'b0, r_fill} + (LB+1)'(1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sample <= i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_cmd.load) begin
            r_fill <= (w_fill_inc < {1'b0, w_lw}) ? LB'(w_fill_inc) : w_lw;
        end
    end

    // ---------------- history addressing ----------------
    logic [AW-1:0] r_pos, w_pos_next;
    logic [AW-1:0] r_rd_addr, w_rd_addr;
    logic [AW-1:0] r_k;
    logic [XW-1:0] w_diff_long, w_diff_short;
    logic [AW-1:0] w_old_long, w_old_short;

    assign w_pos_next = (r_pos == AW'(MAX_WINDOW - 1)) ? '0 : r_pos + AW'(1);

    always_comb begin
        w_diff_long  = XW'(r_pos) - XW'(w_lw);
        w_diff_short = XW'(r_pos) - XW'(w_sw);
        w_old_long   = w_diff_long[XW-1]  ? AW'(w_diff_long + XW'(MAX_WINDOW))
                                          : AW'(w_diff_long);
        w_old_short  = w_diff_short[XW-1] ? AW'(w_diff_short + XW'(MAX_WINDOW))
                                          : AW'(w_diff_short);
    end

    always_comb begin
        unique case (i_cmd.rd_src)
            sle_pkg::RD_OLD_LONG:  w_rd_addr = w_old_long;
            sle_pkg::RD_OLD_SHORT: w_rd_addr = w_old_short;
            sle_pkg::RD_SWEEP:     w_rd_addr = r_rd_addr;
            default:               w_rd_addr = r_rd_addr;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (i_cmd.write) begin
            r_pos <= w_pos_next;
        end
    end

    // sweep walks backward from the newest entry
    always_ff @(posedge i_clk) begin
        if (i_cmd.write) begin
            r_rd_addr <= r_pos;
            r_k       <= '0;
        end else if (i_cmd.sweep) begin
            r_rd_addr <= (r_rd_addr == '0) ? AW'(MAX_WINDOW - 1) : r_rd_addr - AW'(1);
            r_k       <= r_k + AW'(1);
        end
    end

    // ---------------- history memory ----------------
    logic [SAMPLE_BITS-1:0] r_hist [MAX_WINDOW];
    logic [SAMPLE_BITS-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_cmd.write) begin
            r_hist[r_pos] <= r_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_data <= r_hist[w_rd_addr];
        end
    end

    // ---------------- squarer ----------------
    logic [SAMPLE_BITS-1:0]   w_sq_in, w_mag;
    logic [2*SAMPLE_BITS-1:0] w_prod;
    logic [SQW-1:0]           r_sq;

    always_comb begin
        w_sq_in = (i_cmd.sq_sel == sle_pkg::SQ_SAMPLE) ? r_sample : r_rd_data;
        w_mag   = w_sq_in[SAMPLE_BITS-1] ? (~w_sq_in + SAMPLE_BITS'(1)) : w_sq_in;
        w_prod  = w_mag * w_mag;
    end

    always_ff @(posedge i_clk) begin
        r_sq <= w_prod[SQW-1:0];
    end

    // ---------------- sweep tags: issue -> read -> square -> add ----------------
    logic r_tag_v1, r_tag_s1, r_tag_v2, r_tag_s2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_v1 <= 1'b0;
            r_tag_s1 <= 1'b0;
            r_tag_v2 <= 1'b0;
            r_tag_s2 <= 1'b0;
        end else begin
            r_tag_v1 <= i_cmd.sweep;
            r_tag_s1 <= i_cmd.sweep && (LB'(r_k) < w_sw);
            r_tag_v2 <= r_tag_v1;
            r_tag_s2 <= r_tag_s1;
        end
    end

    // ---------------- energy accumulators ----------------
    logic [EW-1:0] r_long, n_long, r_short, n_short, w_sq_ext;

    assign w_sq_ext = EW'(r_sq);

    function automatic logic [EW-1:0] acc_next(input logic [EW-1:0] cur,
                                               input logic [EW-1:0] sq,
                                               input sle_pkg::t_acc_op op);
        logic [EW-1:0] res;
        unique case (op)
            sle_pkg::ACC_HOLD:  res = cur;
            sle_pkg::ACC_CLEAR: res = '0;
            sle_pkg::ACC_ADD:   res = cur + sq;
            sle_pkg::ACC_SUB:   res = cur - sq;
            default:            res = cur;
        endcase
        return res;
    endfunction

    always_comb begin
        n_long  = r_tag_v2 ? r_long + w_sq_ext  : acc_next(r_long, w_sq_ext, i_cmd.long_op);
        n_short = r_tag_s2 ? r_short + w_sq_ext : acc_next(r_short, w_sq_ext, i_cmd.short_op);
    end

    always_ff @(posedge i_clk) begin
        r_long  <= n_long;
        r_short <= n_short;
    end

    // ---------------- shift-add multiply: P = short*lw, D = long*sw ----------------
    logic [PW-1:0]  r_p, r_d;
    logic [BCW-1:0] r_bit;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_init) begin
            r_p   <= '0;
            r_d   <= '0;
            r_bit <= BCW'(LB - 1);
        end else if (i_cmd.mul_step) begin
            r_p   <= {r_p[PW-2:0], 1'b0} + (w_lw[r_bit] ? PW'(r_short) : PW'(0));
            r_d   <= {r_d[PW-2:0], 1'b0} + (w_sw[r_bit] ? PW'(r_long) : PW'(0));
            r_bit <= r_bit - BCW'(1);
        end
    end

    // ---------------- divide: Q = floor(P * 2^16 / D) ----------------
    logic                        w_ovf;
    logic                        r_ovf;
    logic [PW-1:0]               r_rem;
    logic [INT_W-1:0]            r_nbits;
    logic [RW-1:0]               r_q;
    logic [sle_pkg::QCNT_W-1:0]  r_qcnt;
    logic [PW:0]                 w_trial;
    logic                        w_ge;

    // quotient reaches 2^27 exactly when P >= D * 2^11
    assign w_ovf   = {INT_W'(0), r_p} >= {r_d, INT_W'(0)};
    assign w_trial = {r_rem, r_nbits[INT_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_ovf   <= w_ovf;
            r_rem   <= PW'(r_p >> INT_W);
            r_nbits <= r_p[INT_W-1:0];
            r_q     <= '0;
            r_qcnt  <= sle_pkg::QCNT_W'(RW - 1);
        end else if (i_cmd.div_step) begin
            r_rem   <= w_ge ? PW'(w_trial - {1'b0, r_d}) : PW'(w_trial);
            r_nbits <= {r_nbits[INT_W-2:0], 1'b0};
            r_q     <= {r_q[RW-2:0], w_ge};
            r_qcnt  <= r_qcnt - sle_pkg::QCNT_W'(1);
        end
    end

    // ---------------- result register ----------------
    logic [RW-1:0] r_ratio;
    logic          r_zero;

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_zero <= (r_long == '0);
            if (r_long == '0) begin
                r_ratio <= '0;
            end else if (r_ovf) begin
                r_ratio <= '1;
            end else begin
                r_ratio <= r_q;
            end
        end
    end

    assign o_ratio     = r_ratio;
    assign o_zero_flag = r_zero;

    always_comb begin
        o_status.full       = (r_fill == w_lw);
        o_status.sweep_last = (LB'(r_k) == (w_lw - LB'(1)));
        o_status.mul_last   = (r_bit == '0);
        o_status.div_last   = (r_qcnt == '0);
        o_status.zero       = (r_long == '0);
        o_status.ovf        = w_ovf;
    end

endmodule

`default_nettype wire

### hdl/sta_lta_energy_ratio_core.sv
// With the sums current, a sample is captured, the samples leaving both windows are read,
// the sums updated, the ratio multiplied and divided, and the output register loaded; the
// divide is skipped when the long energy is zero or the ratio saturates. A first result
// after reset or a window write sweeps the history instead. Samples before the window fills
// are only stored. One sample in flight: the next is taken once the result is loaded into
// the output register, which waits while the result side holds off a full output register.
// Reset (synchronous, i_rst_n low) clears fill count, write position and handshakes; no RAM clear.
`default_nettype none

module sta_lta_energy_ratio_core #(
    parameter int MAX_WINDOW  = 1024,
    parameter int SAMPLE_BITS = 24
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    sle_sample_if.sink                          i_in,
    sle_result_if.source                        o_out,
    input  wire logic                           i_cfg_we,
    input  wire logic [sle_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [sle_pkg::CFG_W-1:0]      i_cfg_data
);

    // Architecture
    //  - sle_ctrl sequences each transaction: capture, decide, update sums,
    //    multiply, divide, then park the result in the output register.
    //  - sle_datapath owns the sample history RAM (one write or one read per
    //    cycle, registered read), a single squarer, the two energy sums, the
    //    bit-serial multiplier and the restoring divider.
    //
    // Sums are kept running: each new sample adds its square and drops the
    // squares of the samples leaving the short and long windows. The running
    // sums are rebuilt by sweeping the history whenever they are not known
    // good (after reset, or after any configuration write).
    //
    // Ratio = (short * lw * 2^16) / (long * sw), saturating at 2^27-1; a zero
    // long energy gives ratio 0 with status set.

    sle_pkg::t_cmd                 w_cmd;
    sle_pkg::t_status              w_status;
    logic                          w_in_ready;
    logic                          w_out_valid;
    logic [sle_pkg::RATIO_W-1:0]   w_ratio;
    logic                          w_zero_flag;

    sle_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .i_cfg_we    (i_cfg_we),
        .i_status    (w_status),
        .o_cmd       (w_cmd),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid)
    );

    sle_datapath #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sample    (i_in.sample),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_ratio     (w_ratio),
        .o_zero_flag (w_zero_flag)
    );

    // Drive the channel ports
    assign i_in.ready   = w_in_ready;
    assign o_out.valid  = w_out_valid;
    assign o_out.ratio  = w_ratio;
    assign o_out.status = w_zero_flag;

    // ---------------- assertions ----------------

    // Hold off a second transaction while one is being processed
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input accepted while previous sample in progress");

    // Never overwrite a result that has not been taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> (!o_out.valid || o_out.ready))
        else $error("result register overwritten before transaction completed");

    // Zero long energy forces ratio to zero
    a_zero_ratio: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status) |-> (o_out.ratio == '0))
        else $error("status flag set with nonzero ratio");

    // History reads and writes never share a cycle
    a_rw_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.write && w_cmd.rd_en))
        else $error("history read and write issued together");

endmodule

`default_nettype wire

### dv/sta_lta_energy_ratio_core_tb.sv
// Testbench for sta_lta_energy_ratio_core: a directed table, then random sample phases.
// Every result is checked against a hand-typed value or an in-bench short/long ratio predictor.
// Depends on sle_pkg, sle_sample_if, sle_result_if and the core RTL.
`timescale 1ns / 100ps

module sta_lta_energy_ratio_core_tb;

    localparam int MAX_WINDOW       = 1024;
    localparam int SAMPLE_BITS      = 24;
    localparam int SETTLE_CYCLES    = 64;    // lets a sample that gives no result finish
    localparam int TAIL_CYCLES      = 120;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int MAX_REPORTS      = 10;
    localparam int N_PHASES         = 6;
    localparam int PAUSE_PHASE      = 3;
    localparam int HOLD_PHASE       = 4;
    localparam int TIMEOUT_NS       = 25_000_000;

    localparam logic [sle_pkg::RATIO_W-1:0] RATIO_SAT = {sle_pkg::RATIO_W{1'b1}};
    localparam logic [sle_pkg::RATIO_W-1:0] RATIO_ONE =
        sle_pkg::RATIO_W'(2**sle_pkg::FRAC_W);
    localparam logic [sle_pkg::RATIO_W-1:0] RATIO_TWO =
        sle_pkg::RATIO_W'(2 * 2**sle_pkg::FRAC_W);

    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_NO_ENERGY = 1'b1;

    localparam logic [SAMPLE_BITS-1:0] SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    typedef struct packed {
        logic [sle_pkg::RATIO_W-1:0] ratio;
        logic                        status;
    } t_ratio_res;

    typedef enum logic {
        ROW_SAMPLE,
        ROW_REG_WRITE
    } t_row_kind;

    // One line of the directed table: a register write or a sample, optionally with
    // the expected result typed in by hand.
    typedef struct packed {
        t_row_kind                     kind;
        logic [sle_pkg::CFG_IDX_W-1:0] reg_index;
        logic [sle_pkg::CFG_W-1:0]     reg_value;
        logic [SAMPLE_BITS-1:0]        sample;
        logic                          hand_checked;
        t_ratio_res                    hand_result;
    } t_stim_row;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_cfg_we;
    logic [sle_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [sle_pkg::CFG_W-1:0]     i_cfg_data;

    sle_sample_if #(.SAMPLE_BITS(SAMPLE_BITS)) sample_ch ();
    sle_result_if                              ratio_ch ();

    sta_lta_energy_ratio_core #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (sample_ch),
        .o_out       (ratio_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Predictor state: its own copy of the sample history, fill level and window registers.
    logic [SAMPLE_BITS-1:0]    hist_mem [MAX_WINDOW];
    int unsigned               hist_wr;
    int unsigned               hist_fill;
    logic [sle_pkg::CFG_W-1:0] sta_len_reg;
    logic [sle_pkg::CFG_W-1:0] lta_len_reg;
    t_ratio_res                pending_ratios [$];
    int unsigned               fault_count = 0;

    // Stimulus shaping state.
    int unsigned zero_run_left   = 0;
    int unsigned tx_stretch_left = 0;
    bit          tx_gappy        = 1'b0;
    bit          end_calm        = 1'b0;

    // Receiver state: the hold request is a ticket bumped by the sender side.
    int unsigned hold_ticket  = 0;
    int unsigned hold_seen    = 0;
    int unsigned stall_left   = 0;
    int unsigned rx_calm_left = 0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("sta_lta_energy_ratio_core_tb: done, errors");
        $finish;
    end

    // Advance the predictor by one accepted sample. Return 1 and the expected result when the
    // long window is full; the sums are rebuilt from history every time, as the block defines.
    function automatic bit predict_ratio(input logic [SAMPLE_BITS-1:0] smp,
                                         output t_ratio_res res);
        int unsigned            lw;
        int unsigned            sw;
        int unsigned            pos;
        int unsigned            k;
        logic [SAMPLE_BITS-1:0] v;
        logic [SAMPLE_BITS-1:0] mag;
        logic [127:0]           wide_mag;
        logic [127:0]           sta_sum;
        logic [127:0]           lta_sum;
        logic [127:0]           num;
        logic [127:0]           den;
        logic [127:0]           quo;

        // Clamp the windows: zero means one, long caps at the history depth,
        // short caps at the long window.
        lw = lta_len_reg;
        if (lw < 1) lw = 1;
        if (lw > MAX_WINDOW) lw = MAX_WINDOW;
        sw = sta_len_reg;
        if (sw < 1) sw = 1;
        if (sw > lw) sw = lw;

        pos = hist_wr % MAX_WINDOW;
        hist_mem[pos] = smp;
        hist_wr = (pos + 1) % MAX_WINDOW;
        hist_fill = (hist_fill + 1 < lw) ? hist_fill + 1 : lw;

        res = '0;
        if (hist_fill < lw) return 1'b0;

        sta_sum = '0;
        lta_sum = '0;
        for (k = 0; k < lw; k++) begin
            v = hist_mem[(pos + MAX_WINDOW - k) % MAX_WINDOW];
            mag = v[SAMPLE_BITS-1] ? (~v + 1'b1) : v;
            wide_mag = mag;
            lta_sum += wide_mag * wide_mag;
            if (k < sw) sta_sum += wide_mag * wide_mag;
        end

        if (lta_sum == 0) begin
            res.ratio  = '0;
            res.status = STATUS_NO_ENERGY;
        end else begin
            // (S / sw) / (L / lw) in Q.16, truncated; saturate if it ever overflows
            num = (sta_sum * lw) << sle_pkg::FRAC_W;
            den = lta_sum * sw;
            quo = num / den;
            res.ratio  = (quo > RATIO_SAT) ? RATIO_SAT : quo[sle_pkg::RATIO_W-1:0];
            res.status = STATUS_OK;
        end
        return 1'b1;
    endfunction

    function automatic t_stim_row reg_row(input logic [sle_pkg::CFG_IDX_W-1:0] idx,
                                          input logic [sle_pkg::CFG_W-1:0]     val);
        t_stim_row row;
        row = '0;
        row.kind      = ROW_REG_WRITE;
        row.reg_index = idx;
        row.reg_value = val;
        return row;
    endfunction

    function automatic t_stim_row smp_row(input logic [SAMPLE_BITS-1:0] smp);
        t_stim_row row;
        row = '0;
        row.kind   = ROW_SAMPLE;
        row.sample = smp;
        return row;
    endfunction

    function automatic t_stim_row chk_row(input logic [SAMPLE_BITS-1:0] smp,
                                          input logic [sle_pkg::RATIO_W-1:0] ratio,
                                          input logic status);
        t_stim_row row;
        row = smp_row(smp);
        row.hand_checked       = 1'b1;
        row.hand_result.ratio  = ratio;
        row.hand_result.status = status;
        return row;
    endfunction

    // Draw one random sample: full-scale noise most often, with smaller 9-bit and 21-bit
    // values, rail values and runs of silence long enough to empty a short long window.
    function automatic logic [SAMPLE_BITS-1:0] draw_sample(input int unsigned lw);
        logic [31:0] r;
        int unsigned pick;
        if (zero_run_left > 0) begin
            zero_run_left--;
            return '0;
        end
        r = $urandom;
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
            zero_run_left = (lw <= 32) ? $urandom_range(1, lw + 2) : $urandom_range(1, 8);
            return '0;
        end else if (pick == 1) begin
            return r[0] ? SMP_MAX : SMP_MIN;
        end else if (pick < 10) begin
            return r[SAMPLE_BITS-1:0];
        end else if (pick < 16) begin
            return {{(SAMPLE_BITS-9){r[8]}}, r[8:0]};
        end
        return {{(SAMPLE_BITS-21){r[20]}}, r[20:0]};
    endfunction

    // Idle gap before the next sample: stretches with occasional idle gaps alternate
    // with stretches that have none; no gaps at all near the end.
    function automatic int draw_gap();
        if (end_calm) return 0;
        if (tx_stretch_left == 0) begin
            tx_stretch_left = $urandom_range(20, 80);
            tx_gappy = ($urandom_range(0, 2) != 0);
        end
        tx_stretch_left--;
        return (tx_gappy && $urandom_range(0, 3) == 0) ? $urandom_range(1, 11) : 0;
    endfunction

    // Compare one accepted result transaction with the oldest expectation.
    task automatic check_ratio(input logic [sle_pkg::RATIO_W-1:0] ratio, input logic status);
        t_ratio_res want;
        if (pending_ratios.size() == 0) begin
            fault_count++;
            if (fault_count <= MAX_REPORTS)
                $display("%0t: result with none pending: ratio=%0d status=%0b",
                         $time, ratio, status);
        end else begin
            want = pending_ratios.pop_front();
            if (want.ratio !== ratio || want.status !== status) begin
                fault_count++;
                if (fault_count <= MAX_REPORTS)
                    $display({"%0t: mismatch: expected ratio=%0d status=%0b, ",
                              "got ratio=%0d status=%0b"},
                             $time, want.ratio, want.status, ratio, status);
            end
        end
    endtask

    // Result side: check each handshake at the edge, then pick ready for the next cycle.
    // A bumped hold ticket forces a long stall so that the core backs up into its input.
    always @(posedge i_clk) begin
        if (ratio_ch.valid === 1'b1 && ratio_ch.ready === 1'b1)
            check_ratio(ratio_ch.ratio, ratio_ch.status);

        if (hold_ticket != hold_seen) begin
            hold_seen  = hold_ticket;
            stall_left = LONG_HOLD_CYCLES;
        end

        if (rx_calm_left > 0)
            rx_calm_left--;
        else if ($urandom_range(0, 99) == 0)
            rx_calm_left = $urandom_range(30, 150);

        if (!i_rst_n) begin
            ratio_ch.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            ratio_ch.ready <= 1'b0;
        end else if (!end_calm && rx_calm_left == 0 && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 11) - 1;
            ratio_ch.ready <= 1'b0;
        end else begin
            ratio_ch.ready <= 1'b1;
        end
    end

    // Drop valid and wait until every expected result has been taken, then let the
    // core settle: a sample that gives no result may still be in flight.
    task automatic wait_drained(input int settle);
        sample_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending_ratios.size() != 0);
        repeat (settle) @(posedge i_clk);
    endtask

    // Write one window register; the predictor copy follows at once since the core is idle.
    task automatic write_reg(input logic [sle_pkg::CFG_IDX_W-1:0] idx,
                             input logic [sle_pkg::CFG_W-1:0]     val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        if (idx == sle_pkg::REG_SHORT_WINDOW)
            sta_len_reg = val;
        else
            lta_len_reg = val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Offer one sample transaction after an optional idle gap; hold valid until accepted,
    // then queue the hand-typed or predicted result if this sample gives one.
    task automatic send_sample(input logic [SAMPLE_BITS-1:0] smp, input int gap,
                               input bit hand_checked, input t_ratio_res hand_res);
        t_ratio_res res;
        if (gap > 0) begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        sample_ch.valid  <= 1'b1;
        sample_ch.sample <= smp;
        do @(posedge i_clk); while (sample_ch.ready !== 1'b1);
        if (predict_ratio(smp, res))
            pending_ratios.push_back(hand_checked ? hand_res : res);
    endtask

    initial begin
        t_stim_row                 plan [$];
        logic [sle_pkg::CFG_W-1:0] phase_sta [N_PHASES];
        logic [sle_pkg::CFG_W-1:0] phase_lta [N_PHASES];
        int unsigned               phase_items [N_PHASES];

        i_rst_n          <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_index      <= sle_pkg::REG_SHORT_WINDOW;
        i_cfg_data       <= '0;
        sample_ch.valid  <= 1'b0;
        sample_ch.sample <= '0;

        hist_wr     = 0;
        hist_fill   = 0;
        sta_len_reg = sle_pkg::SHORT_WINDOW_RST;
        lta_len_reg = sle_pkg::LONG_WINDOW_RST;

        // Directed table. Start with a 4-sample long window; the reset short window (32)
        // is clamped down to it.
        plan.push_back(reg_row(sle_pkg::REG_LONG_WINDOW, 11'd4));
        plan.push_back(smp_row('0));
        plan.push_back(smp_row('0));
        plan.push_back(smp_row('0));
        // Window just filled with silence: zero long energy forces ratio 0 and the flag.
        plan.push_back(chk_row('0, '0, STATUS_NO_ENERGY));
        plan.push_back(chk_row('0, '0, STATUS_NO_ENERGY));
        // Short window of 2 inside a long window of 4: rail samples on a silent
        // background give exactly twice the long mean.
        plan.push_back(reg_row(sle_pkg::REG_SHORT_WINDOW, 11'd2));
        plan.push_back(chk_row(SMP_MAX, RATIO_TWO, STATUS_OK));
        plan.push_back(chk_row(SMP_MIN, RATIO_TWO, STATUS_OK));
        plan.push_back(smp_row('1));
        plan.push_back(smp_row(24'h000001));
        plan.push_back(smp_row(24'h555555));
        plan.push_back(smp_row(24'hAAAAAA));
        // Zero in both registers means one-sample windows: any nonzero sample is unity.
        plan.push_back(reg_row(sle_pkg::REG_SHORT_WINDOW, '0));
        plan.push_back(reg_row(sle_pkg::REG_LONG_WINDOW, '0));
        plan.push_back(chk_row('0, '0, STATUS_NO_ENERGY));
        plan.push_back(chk_row(24'd5, RATIO_ONE, STATUS_OK));
        plan.push_back(chk_row(SMP_MIN, RATIO_ONE, STATUS_OK));
        // Short window at its register maximum clamps to the long window: unity again,
        // and the long window grows, so the first sample must wait for the fill.
        plan.push_back(reg_row(sle_pkg::REG_LONG_WINDOW, 11'd3));
        plan.push_back(reg_row(sle_pkg::REG_SHORT_WINDOW, {sle_pkg::CFG_W{1'b1}}));
        plan.push_back(smp_row(24'd7));
        plan.push_back(chk_row(-24'sd7, RATIO_ONE, STATUS_OK));
        plan.push_back(chk_row('0, RATIO_ONE, STATUS_OK));

        // Random phases: reset-value windows, the register extremes (long window clamped
        // to the history depth), then small windows where results come with every sample.
        phase_sta   = '{sle_pkg::SHORT_WINDOW_RST, 11'd1, 11'd2047, 11'd3, 11'd1, 11'd5};
        phase_lta   = '{sle_pkg::LONG_WINDOW_RST, 11'd2047, 11'd2047, 11'd20, 11'd1, 11'd8};
        phase_items = '{530, 530, 60, 150, 60, 200};

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_REG_WRITE) begin
                wait_drained(SETTLE_CYCLES);
                write_reg(plan[i].reg_index, plan[i].reg_value);
            end else begin
                send_sample(plan[i].sample, draw_gap(), plan[i].hand_checked,
                            plan[i].hand_result);
            end
        end

        for (int p = 0; p < N_PHASES; p++) begin
            wait_drained(SETTLE_CYCLES);
            write_reg(sle_pkg::REG_SHORT_WINDOW, phase_sta[p]);
            write_reg(sle_pkg::REG_LONG_WINDOW, phase_lta[p]);
            zero_run_left = 0;
            // Every sample gives a result here: stall the result side for a long stretch
            // while samples keep coming, so the core fills up and backs off its input.
            if (p == HOLD_PHASE) hold_ticket <= hold_ticket + 1;
            // Last phase runs with no idling on either side.
            if (p == N_PHASES - 1) end_calm <= 1'b1;
            for (int n = 0; n < phase_items[p]; n++) begin
                // Halfway through, hold off the input until every result is out.
                if (p == PAUSE_PHASE && n == phase_items[p] / 2) wait_drained(0);
                send_sample(draw_sample(phase_lta[p]), draw_gap(), 1'b0, '0);
            end
        end

        wait_drained(TAIL_CYCLES);
        if (fault_count == 0)
            $display("sta_lta_energy_ratio_core_tb: done, clean");
        else
            $display("sta_lta_energy_ratio_core_tb: done, errors");
        $finish;
    end

endmodule
